// ===== src/mppt_pkg.sv =====
// Shared types, register indexes, reset values and duty helpers for the
// MPPT charge controller. No dependencies.
package mppt_pkg;

  localparam int SAMPLE_BITS   = 15;
  localparam int DUTY_BITS     = 8;
  localparam int POWER_BITS    = 2 * SAMPLE_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [DUTY_BITS-1:0]     duty_t;
  typedef logic [POWER_BITS-1:0]    power_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t CFG_TARGET_VOLTAGE    = 3'd0;
  localparam cfg_idx_t CFG_STEADY_CURRENT    = 3'd1;
  localparam cfg_idx_t CFG_MAX_CURRENT       = 3'd2;
  localparam cfg_idx_t CFG_DUTY_STEP         = 3'd3;
  localparam cfg_idx_t CFG_LOW_CURRENT_LIMIT = 3'd4;

  // reset values
  localparam sample_t RST_TARGET_VOLTAGE    = 15'd0;
  localparam sample_t RST_STEADY_CURRENT    = 15'd150;
  localparam sample_t RST_MAX_CURRENT       = 15'd5000;
  localparam duty_t   RST_DUTY_STEP         = 8'd1;
  localparam sample_t RST_LOW_CURRENT_LIMIT = 15'd10;
  localparam power_t  RST_LAST_POWER        = 30'd20;
  localparam sample_t RST_LAST_PANEL_V      = 15'd0;

  typedef enum logic [1:0] {
    MODE_MPPT    = 2'd0,
    MODE_TAPER   = 2'd1,
    MODE_OVERCUR = 2'd2,
    MODE_DONE    = 2'd3
  } mode_e;

  typedef struct packed {
    sample_t target_voltage;
    sample_t steady_current;
    sample_t max_current;
    duty_t   duty_step;
    sample_t low_current_limit;
  } cfg_t;

  typedef struct packed {
    sample_t battery_voltage;
    sample_t battery_current;
    sample_t panel_voltage;
    sample_t panel_current;
    duty_t   duty_in;
  } sample_set_t;

  typedef struct packed {
    duty_t duty_out;
    logic  charge_done;
    mode_e mode;
  } result_t;

  // operating point of the last MPPT sample
  typedef struct packed {
    power_t  power;
    sample_t panel_voltage;
  } track_t;

  function automatic duty_t duty_up(duty_t d, duty_t step);
    logic [DUTY_BITS:0] sum;
    sum = {1'b0, d} + {1'b0, step};
    return sum[DUTY_BITS] ? {DUTY_BITS{1'b1}} : sum[DUTY_BITS-1:0];
  endfunction

  function automatic duty_t duty_down(duty_t d, duty_t step);
    return (d < step) ? '0 : d - step;
  endfunction

endpackage

// ===== src/mppt_sample_if.sv =====
// Sample set channel: valid/ready handshake plus one word of measurements.
// Depends on mppt_pkg.
interface mppt_sample_if;
  logic             valid;
  logic             ready;
  mppt_pkg::sample_t battery_voltage;
  mppt_pkg::sample_t battery_current;
  mppt_pkg::sample_t panel_voltage;
  mppt_pkg::sample_t panel_current;
  mppt_pkg::duty_t   duty_in;

  modport source (output valid, battery_voltage, battery_current, panel_voltage,
                  panel_current, duty_in, input ready);
  modport sink   (input valid, battery_voltage, battery_current, panel_voltage,
                  panel_current, duty_in, output ready);
endinterface

// ===== src/mppt_result_if.sv =====
// Result channel: valid/ready handshake plus new duty, done flag and mode.
// Depends on mppt_pkg.
interface mppt_result_if;
  logic            valid;
  logic            ready;
  mppt_pkg::duty_t duty_out;
  logic            charge_done;
  logic [1:0]      mode;

  modport source (output valid, duty_out, charge_done, mode, input ready);
  modport sink   (input valid, duty_out, charge_done, mode, output ready);
endinterface

// ===== src/mppt_charge_controller_top.sv =====
// MPPT charge controller top level: sample register, decision logic,
// result register, configuration registers. Depends on mppt_pkg, mppt_step
// and the two channel interfaces.
// A word accepted into the sample register moves on to the result register once that
// register is free or being emptied. Throughput: one word per cycle while results are
// taken; the whole decision (one 15x15 multiply and compares) sits between them.
// Reset (rst_ni low, async): channels empty, registers at their defaults,
// tracking state at power 20 and panel voltage 0.
module mppt_charge_controller_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  mppt_pkg::cfg_idx_t   cfg_idx_i,
  input  mppt_pkg::cfg_data_t  cfg_data_i,
  mppt_sample_if.sink          sample_i,
  mppt_result_if.source        result_o
);
  import mppt_pkg::*;

  // configuration registers
  cfg_t        cfg_q;

  // sample stage
  logic        s1_vld_q;
  sample_set_t s1_smp_q;
  logic        s1_adv;

  // result stage
  logic        out_vld_q;
  result_t     out_res_q;

  // operating point of the last MPPT sample
  track_t      trk_q;

  result_t     step_res;
  track_t      step_trk;
  logic        step_upd;

  // The sample stage moves on whenever the result register is free or being
  // emptied this cycle, so a new input word is taken every cycle unless both
  // stages are full and the waiting result is held off.
  assign s1_adv         = s1_vld_q && (!out_vld_q || result_o.ready);
  assign sample_i.ready = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_voltage    <= RST_TARGET_VOLTAGE;
      cfg_q.steady_current    <= RST_STEADY_CURRENT;
      cfg_q.max_current       <= RST_MAX_CURRENT;
      cfg_q.duty_step         <= RST_DUTY_STEP;
      cfg_q.low_current_limit <= RST_LOW_CURRENT_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_VOLTAGE:    cfg_q.target_voltage    <= cfg_data_i;
        CFG_STEADY_CURRENT:    cfg_q.steady_current    <= cfg_data_i;
        CFG_MAX_CURRENT:       cfg_q.max_current       <= cfg_data_i;
        CFG_DUTY_STEP:         cfg_q.duty_step         <= cfg_data_i[DUTY_BITS-1:0];
        CFG_LOW_CURRENT_LIMIT: cfg_q.low_current_limit <= cfg_data_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      s1_smp_q.battery_voltage <= sample_i.battery_voltage;
      s1_smp_q.battery_current <= sample_i.battery_current;
      s1_smp_q.panel_voltage   <= sample_i.panel_voltage;
      s1_smp_q.panel_current   <= sample_i.panel_current;
      s1_smp_q.duty_in         <= sample_i.duty_in;
    end
  end

  mppt_step u_step (
    .cfg_i (cfg_q),
    .smp_i (s1_smp_q),
    .trk_i (trk_q),
    .res_o (step_res),
    .trk_o (step_trk),
    .upd_o (step_upd)
  );

  // Tracking state follows only MPPT-mode words, and only as they leave the
  // sample stage, so each word sees the point of the last MPPT word before it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q.power         <= RST_LAST_POWER;
      trk_q.panel_voltage <= RST_LAST_PANEL_V;
    end else if (s1_adv && step_upd) begin
      trk_q <= step_trk;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= step_res;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.duty_out    = out_res_q.duty_out;
  assign result_o.charge_done = out_res_q.charge_done;
  assign result_o.mode        = out_res_q.mode;

  // done flag and done mode always travel together, with the converter off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_res_q.charge_done == (out_res_q.mode == MODE_DONE)))
    else $error("charge_done and mode disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.charge_done) |-> (out_res_q.duty_out == '0))
    else $error("charge done with non-zero duty");

  // tracking state moves only on MPPT words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trk_q != $past(trk_q)) |-> ($past(s1_adv) && $past(step_res.mode) == MODE_MPPT))
    else $error("tracking state changed outside MPPT mode");

  // a full pipe with a stalled result must not take another word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !result_o.ready) |-> !sample_i.ready)
    else $error("input accepted while both stages are held");

endmodule

// ===== src/mppt_step.sv =====
// Per-sample decision logic: CC/CV checks and perturb-and-observe tracking.
// Purely combinational; depends on mppt_pkg.
module mppt_step (
  input  mppt_pkg::cfg_t        cfg_i,
  input  mppt_pkg::sample_set_t smp_i,
  input  mppt_pkg::track_t      trk_i,
  output mppt_pkg::result_t     res_o,
  output mppt_pkg::track_t      trk_o,
  output logic                  upd_o
);
  import mppt_pkg::*;

  power_t power;
  logic   rising;
  duty_t  up_duty;
  duty_t  dn_duty;
  duty_t  mppt_duty;

  assign power   = power_t'(smp_i.panel_voltage) * power_t'(smp_i.panel_current);
  assign up_duty = duty_up(smp_i.duty_in, cfg_i.duty_step);
  assign dn_duty = duty_down(smp_i.duty_in, cfg_i.duty_step);

  // low panel current demands a strict rise in power
  assign rising = (smp_i.panel_current >= cfg_i.low_current_limit)
                ? (power >= trk_i.power) : (power > trk_i.power);

  always_comb begin
    if (power == '0) begin
      mppt_duty = up_duty;
    end else if (rising) begin
      mppt_duty = (smp_i.panel_voltage > trk_i.panel_voltage) ? dn_duty : up_duty;
    end else begin
      mppt_duty = (smp_i.panel_voltage >= trk_i.panel_voltage) ? up_duty : dn_duty;
    end
  end

  always_comb begin
    res_o.charge_done = 1'b0;
    upd_o             = 1'b0;
    if (smp_i.battery_voltage >= cfg_i.target_voltage) begin
      if (smp_i.battery_current <= cfg_i.steady_current) begin
        res_o.duty_out    = '0;
        res_o.charge_done = 1'b1;
        res_o.mode        = MODE_DONE;
      end else begin
        res_o.duty_out = dn_duty;
        res_o.mode     = MODE_TAPER;
      end
    end else if (smp_i.battery_current >= cfg_i.max_current) begin
      res_o.duty_out = dn_duty;
      res_o.mode     = MODE_OVERCUR;
    end else begin
      res_o.duty_out = mppt_duty;
      res_o.mode     = MODE_MPPT;
      upd_o          = 1'b1;
    end
  end

  assign trk_o.power         = power;
  assign trk_o.panel_voltage = smp_i.panel_voltage;

endmodule

// ===== tb/sv/tb_duty_tracker_pkg.sv =====
`timescale 1ns / 1ps
// Duty tracker for the MPPT charge controller testbench: predicts each result
// word from the sample words and register writes seen. Depends on mppt_pkg.
package tb_duty_tracker_pkg;
  import mppt_pkg::*;

  localparam int DUTY_TOP = (1 << DUTY_BITS) - 1;

  class duty_tracker;
    cfg_t    cfg;
    track_t  last;
    result_t pending_duties[$];
    int      errors;
    int      checked;
    int      hits[4];

    function new();
      cfg.target_voltage    = RST_TARGET_VOLTAGE;
      cfg.steady_current    = RST_STEADY_CURRENT;
      cfg.max_current       = RST_MAX_CURRENT;
      cfg.duty_step         = RST_DUTY_STEP;
      cfg.low_current_limit = RST_LOW_CURRENT_LIMIT;
      last.power            = RST_LAST_POWER;
      last.panel_voltage    = RST_LAST_PANEL_V;
      errors  = 0;
      checked = 0;
      foreach (hits[i]) hits[i] = 0;
    endfunction

    // mirrors a register write; unknown indexes change nothing
    function void set_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        CFG_TARGET_VOLTAGE:    cfg.target_voltage    = sample_t'(data);
        CFG_STEADY_CURRENT:    cfg.steady_current    = sample_t'(data);
        CFG_MAX_CURRENT:       cfg.max_current       = sample_t'(data);
        CFG_DUTY_STEP:         cfg.duty_step         = data[DUTY_BITS-1:0];
        CFG_LOW_CURRENT_LIMIT: cfg.low_current_limit = sample_t'(data);
        default: ;
      endcase
    endfunction

    function duty_t raise(duty_t d);
      int s;
      s = int'(d) + int'(cfg.duty_step);
      return duty_t'((s > DUTY_TOP) ? DUTY_TOP : s);
    endfunction

    function duty_t lower(duty_t d);
      int s;
      s = int'(d) - int'(cfg.duty_step);
      return duty_t'((s < 0) ? 0 : s);
    endfunction

    // perturb and observe against the last tracking point, then move it on
    function duty_t track_point(sample_t pv, sample_t pi, duty_t d);
      power_t p;
      logic   rising;
      duty_t  nd;
      p = power_t'(pv) * power_t'(pi);
      if (p == '0) begin
        nd = raise(d);
      end else begin
        if (pi >= cfg.low_current_limit) rising = (p >= last.power);
        else rising = (p > last.power);
        if (rising) nd = (pv > last.panel_voltage) ? lower(d) : raise(d);
        else nd = (pv >= last.panel_voltage) ? raise(d) : lower(d);
      end
      last.power         = p;
      last.panel_voltage = pv;
      return nd;
    endfunction

    function void note_sample(sample_set_t s);
      result_t r;
      r.charge_done = 1'b0;
      if (s.battery_voltage >= cfg.target_voltage) begin
        if (s.battery_current <= cfg.steady_current) begin
          r.duty_out    = '0;
          r.charge_done = 1'b1;
          r.mode        = MODE_DONE;
        end else begin
          r.duty_out = lower(s.duty_in);
          r.mode     = MODE_TAPER;
        end
      end else if (s.battery_current >= cfg.max_current) begin
        r.duty_out = lower(s.duty_in);
        r.mode     = MODE_OVERCUR;
      end else begin
        r.duty_out = track_point(s.panel_voltage, s.panel_current, s.duty_in);
        r.mode     = MODE_MPPT;
      end
      hits[int'(r.mode)]++;
      pending_duties.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_duties.size() == 0) begin
        $display("%0t: result word with none pending: duty %0d done %0d mode %0d",
                 $time, got.duty_out, got.charge_done, got.mode);
        errors++;
        return;
      end
      want = pending_duties.pop_front();
      checked++;
      if (got.duty_out !== want.duty_out) begin
        $display("%0t: duty_out expected %0d actual %0d", $time, want.duty_out, got.duty_out);
        errors++;
      end
      if (got.charge_done !== want.charge_done) begin
        $display("%0t: charge_done expected %0d actual %0d", $time, want.charge_done,
                 got.charge_done);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
        errors++;
      end
    endfunction

    function int pending();
      return pending_duties.size();
    endfunction
  endclass
endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the MPPT charge controller testbench: clock, reset, sample and result
// channel drivers, register writes and stimulus. Depends on mppt_pkg, the two
// channel interfaces and tb_duty_tracker_pkg.
module tb_top;
  import mppt_pkg::*;
  import tb_duty_tracker_pkg::*;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES   = 3;    // settling margin after the last result
  localparam int SAMPLE_TOP      = (1 << SAMPLE_BITS) - 1;
  localparam int JUNK_BITS       = CFG_DATA_BITS - DUTY_BITS;
  // first index past the register file; writes there must be ignored
  localparam cfg_idx_t CFG_FIRST_UNUSED = cfg_idx_t'(CFG_LOW_CURRENT_LIMIT + 1);

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_data_t cfg_data;

  mppt_sample_if smp ();
  mppt_result_if res ();

  // idling controls shared between the stimulus and the receiver
  bit tx_bursts_on;
  bit rx_bursts_on;
  bit hold_req;
  bit hold_active;
  int sent;
  int settings;

  // last panel operating point handed out, so MPPT words can walk around it
  sample_t prev_pv;
  sample_t prev_pi;

  duty_tracker sb = new();

  mppt_charge_controller_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (smp),
    .result_o   (res)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Generous fixed limit; a correct run takes a small fraction of this.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Monitor. Everything is driven by NBA at the edge, so values read here
  // are the ones the DUT saw. The result is checked before the sample is
  // noted, so a result can never be matched against a same-edge sample.
  always @(posedge clk) begin
    result_t     got;
    sample_set_t s;
    if (rst_n === 1'b1) begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        got.duty_out    = res.duty_out;
        got.charge_done = res.charge_done;
        got.mode        = mode_e'(res.mode);
        sb.check_result(got);
      end
      if (smp.valid === 1'b1 && smp.ready === 1'b1) begin
        s.battery_voltage = smp.battery_voltage;
        s.battery_current = smp.battery_current;
        s.panel_voltage   = smp.panel_voltage;
        s.panel_current   = smp.panel_current;
        s.duty_in         = smp.duty_in;
        sb.note_sample(s);
      end
    end
  end

  // Receiver: ready in random bursts, one NBA per pass, and each pass waits on the
  // clock. A long hold-off, when asked for, is counted here.
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end else if (rx_bursts_on && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offers one sample word and waits for it to be taken. valid stays high
  // into the next word unless a gap is drawn, so it is never dropped and
  // raised in one step.
  task automatic send_sample(sample_set_t s);
    if (tx_bursts_on && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    smp.valid           <= 1'b1;
    smp.battery_voltage <= s.battery_voltage;
    smp.battery_current <= s.battery_current;
    smp.panel_voltage   <= s.panel_voltage;
    smp.panel_current   <= s.panel_current;
    smp.duty_in         <= s.duty_in;
    do @(posedge clk); while (smp.ready !== 1'b1);
    sent++;
  endtask

  task automatic put(int bv, int bi, int pv, int pi, int d);
    sample_set_t s;
    s.battery_voltage = sample_t'(bv);
    s.battery_current = sample_t'(bi);
    s.panel_voltage   = sample_t'(pv);
    s.panel_current   = sample_t'(pi);
    s.duty_in         = duty_t'(d);
    send_sample(s);
  endtask

  // Stop offering and wait until every predicted result has come back,
  // then let the pipeline settle. The first edge lets the monitor note a
  // word taken at the current edge.
  task automatic wait_for_results();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high between back-to-back writes; end_writes drops it.
  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  // duty_step write with random junk in the bits above the register width
  task automatic write_step(duty_t st);
    logic [JUNK_BITS-1:0] junk;
    junk = JUNK_BITS'($urandom);
    write_reg(CFG_DUTY_STEP, cfg_data_t'({junk, st}));
  endtask

  task automatic write_unused();
    write_reg(cfg_idx_t'(CFG_FIRST_UNUSED + $urandom_range(0, 2)),
              cfg_data_t'($urandom));
  endtask

  // Register set for each random phase. Phase 0 is an ordinary set, the next ones pin
  // extremes, the rest are random with the odd extreme mixed in.
  task automatic configure(int phase);
    sample_t tv, sc, mc, ll;
    duty_t   st;
    wait_for_results();
    case (phase)
      0: begin
        tv = 15'd20000; sc = 15'd150; mc = 15'd5000; st = 8'd1; ll = 15'd10;
      end
      1: begin
        tv = sample_t'(SAMPLE_TOP); sc = '0; mc = sample_t'(SAMPLE_TOP); st = 8'd255;
        ll = '0;
      end
      2: begin
        // everything lands in taper or done
        tv = '0; sc = sample_t'(SAMPLE_TOP); mc = sample_t'($urandom);
        st = duty_t'($urandom);
        ll = sample_t'(SAMPLE_TOP);
      end
      3: begin
        // anything under the target counts as overcurrent
        tv = sample_t'($urandom_range(1000, SAMPLE_TOP)); sc = sample_t'($urandom_range(0, 500));
        mc = '0; st = duty_t'($urandom_range(1, 16)); ll = sample_t'($urandom_range(0, 100));
      end
      default: begin
        tv = sample_t'($urandom_range(1000, SAMPLE_TOP));
        sc = sample_t'($urandom_range(0, 2000));
        mc = sample_t'(($urandom_range(0, 7) == 0) ? SAMPLE_TOP : $urandom_range(500, 30000));
        st = duty_t'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40));
        ll = sample_t'(($urandom_range(0, 5) == 0) ? SAMPLE_TOP : $urandom_range(0, 2000));
      end
    endcase
    write_reg(CFG_TARGET_VOLTAGE, cfg_data_t'(tv));
    write_reg(CFG_STEADY_CURRENT, cfg_data_t'(sc));
    write_reg(CFG_MAX_CURRENT, cfg_data_t'(mc));
    write_step(st);
    write_reg(CFG_LOW_CURRENT_LIMIT, cfg_data_t'(ll));
    write_unused();
    end_writes();
    settings++;
  endtask

  function automatic sample_t near(int c, int span);
    int v;
    v = c + $urandom_range(0, 2 * span) - span;
    if (v < 0) v = 0;
    if (v > SAMPLE_TOP) v = SAMPLE_TOP;
    return sample_t'(v);
  endfunction

  // Random sample word. Most words are steered into the MPPT region with the
  // panel point walking around the previous one, so the tracker sees rising,
  // falling and level power; the rest go to taper, done, overcurrent or noise.
  task automatic gen_sample(output sample_set_t s);
    int pick, k, tv, mc, ll;
    tv   = int'(sb.cfg.target_voltage);
    mc   = int'(sb.cfg.max_current);
    ll   = int'(sb.cfg.low_current_limit);
    pick = $urandom_range(0, 99);
    s    = sample_set_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) == 0) s.duty_in = $urandom_range(0, 1) ? '1 : '0;
    if (pick >= 15) begin
      if (pick < 70 && tv > 0 && mc > 0) begin
        s.battery_voltage = sample_t'($urandom_range(0, tv - 1));
        s.battery_current = sample_t'($urandom_range(0, mc - 1));
      end else if (pick < 85) begin
        s.battery_voltage = sample_t'($urandom_range(tv, SAMPLE_TOP));
        s.battery_current = $urandom_range(0, 1) ? near(int'(sb.cfg.steady_current), 3)
                                                 : sample_t'($urandom);
      end else begin
        s.battery_voltage = (tv > 0) ? sample_t'($urandom_range(0, tv - 1)) : sample_t'($urandom);
        s.battery_current = sample_t'($urandom_range(mc, SAMPLE_TOP));
      end
      k = $urandom_range(0, 19);
      if (k < 10) begin
        s.panel_voltage = near(int'(prev_pv), 64);
        s.panel_current = near(int'(prev_pi), 64);
      end else if (k < 13) begin
        s.panel_voltage = prev_pv;
        s.panel_current = prev_pi;
      end else if (k < 15) begin
        s.panel_voltage = near(int'(prev_pv), 16);
        s.panel_current = (ll > 0) ? sample_t'($urandom_range(0, ll - 1)) : '0;
      end else if (k == 15) begin
        if ($urandom_range(0, 1)) s.panel_voltage = '0;
        else s.panel_current = '0;
      end
    end
    prev_pv = s.panel_voltage;
    prev_pi = s.panel_current;
  endtask

  initial begin
    sample_set_t s;
    int          n;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    smp.valid           <= 1'b0;
    smp.battery_voltage <= '0;
    smp.battery_current <= '0;
    smp.panel_voltage   <= '0;
    smp.panel_current   <= '0;
    smp.duty_in         <= '0;
    res.ready           <= 1'b0;
    tx_bursts_on = 1'b1;
    rx_bursts_on = 1'b1;
    hold_req     = 1'b0;
    hold_active  = 1'b0;
    sent         = 0;
    settings     = 1;
    prev_pv      = 15'd1000;
    prev_pi      = 15'd100;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: target 0, so every word is taper or done.
    put(0, 0, 123, 45, 200);                  // done, current well below steady
    put(0, 150, 0, 0, 7);                     // done exactly at steady current
    put(0, 151, 0, 0, 0);                     // taper, duty held at zero
    put(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, 255);

    // Ordinary settings; tracking state still at its reset point.
    configure(0);
    put(19999, 5000, 0, 0, 0);                // overcurrent at the limit, saturates low
    put(19999, 4999, 2, 10, 100);             // power level with reset point, voltage up
    put(100, 0, 0, 0, 255);                   // zero power, saturates high
    put(100, 0, 100, 10, 50);                 // rising power, voltage up
    put(100, 0, 100, 10, 50);                 // level power, level voltage
    put(100, 0, 90, 10, 50);                  // falling power, voltage down
    put(100, 0, 100, 9, 50);                  // level power under low-current rule
    put(100, 0, 50, 9, 50);                   // falling power and voltage
    put(100, 0, SAMPLE_TOP, SAMPLE_TOP, 254); // largest product
    put(20000, 150, 0, 0, 9);                 // done at the target
    put(20000, 151, 0, 0, 9);                 // taper at the target
    put(19999, SAMPLE_TOP, 1, 1, 128);        // overcurrent, largest current

    // Largest step: both directions saturate from one step.
    wait_for_results();
    write_step(8'd255);
    write_unused();
    end_writes();
    put(0, 6000, 0, 0, 1);
    put(0, 0, 0, 0, 1);
    // Zero step: adjustments leave the duty alone.
    wait_for_results();
    write_step(8'd0);
    end_writes();
    put(0, 6000, 0, 0, 77);
    put(0, 0, 0, 0, 255);
    settings += 2;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      configure(ph);
      if (ph == NUM_PHASES - 1) begin
        // closing stretch runs flat out on both sides
        tx_bursts_on = 1'b0;
        rx_bursts_on = 1'b0;
      end
      if (ph == 4) begin
        // receiver stalls for a long stretch while words keep coming, so the
        // block fills and holds off its input
        hold_req = 1'b1;
        wait (hold_active);
      end
      n = (ph == 2) ? 20 : ITEMS_PER_PHASE;
      for (int i = 0; i < n; i++) begin
        gen_sample(s);
        send_sample(s);
      end
    end

    wait_for_results();
    $display("covered %0d sample words under %0d register settings, %0d results checked",
             sent, settings, sb.checked);
    $display("modes predicted: mppt %0d, taper %0d, overcurrent %0d, done %0d",
             sb.hits[MODE_MPPT], sb.hits[MODE_TAPER], sb.hits[MODE_OVERCUR],
             sb.hits[MODE_DONE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== mppt_charge_controller_top.f =====
src/mppt_pkg.sv
src/mppt_sample_if.sv
src/mppt_result_if.sv
src/mppt_step.sv
src/mppt_charge_controller_top.sv
tb/sv/tb_duty_tracker_pkg.sv
tb/sv/tb_top.sv
